// ----- design/frfo_pkg.sv -----
// Shared types and codes for the frame region fill and outline block.
// No dependencies.
package frfo_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic KIND_FIND  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] REG_SEED   = 2'd0;
  localparam logic [1:0] REG_COLOR  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic        seed;
    logic [23:0] color;
    logic [8:0]  width;
    logic [8:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [23:0] color;
    logic        stored;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic       in_frame;
    logic       frame_edge;
    logic       off_edge;
    logic       rect_found;
    logic [7:0] rect_left;
    logic [7:0] rect_top;
    logic [8:0] rect_width;
    logic [8:0] rect_height;
  } res_t;

endpackage

// ----- design/frfo_ifs.sv -----
// Item channel interfaces: pixel/query input and result output.
// No dependencies.
interface frfo_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [23:0] pixel_color;
  logic        last_pixel;
  modport source(output valid, cmd, pos_x, pos_y, pixel_color, last_pixel, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, pixel_color, last_pixel, output ready);
endinterface

interface frfo_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic       in_frame;
  logic       frame_edge;
  logic       off_edge;
  logic       rect_found;
  logic [7:0] rect_left;
  logic [7:0] rect_top;
  logic [8:0] rect_width;
  logic [8:0] rect_height;
  modport source(output valid, result_kind, in_frame, frame_edge, off_edge, rect_found,
                 rect_left, rect_top, rect_width, rect_height, input ready);
  modport sink(input valid, result_kind, in_frame, frame_edge, off_edge, rect_found,
               rect_left, rect_top, rect_width, rect_height, output ready);
endinterface

// ----- design/frame_region_fill_outline.sv -----
// Frame region finder top level: config registers, front queue, fill engine.
// Pixel write: stored from the queue head while idle. Query: up to five map reads.
// Find: the region map is cleared, then the flood fill runs (one map/pixel port),
// then the scan visits every in-use pixel.
// After reset the region map is cleared with no item accepted; registers reset
// to seed 1, colour 0, size 256 by 256.
module frame_region_fill_outline import frfo_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  frfo_in_if.sink     in_ch,
  frfo_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed   <= 1'b1;
      cfg.color  <= '0;
      cfg.width  <= 9'd256;
      cfg.height <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:   cfg.seed   <= cfg_data[0];
        REG_COLOR:  cfg.color  <= cfg_data;
        REG_WIDTH:  cfg.width  <= cfg_data[8:0];
        REG_HEIGHT: cfg.height <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  frfo_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .hold(clearing),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  frfo_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_item(q_item), .q_valid(q_valid),
    .q_pop(q_pop), .clearing(clearing), .out_ch(out_ch)
  );

endmodule

// ----- design/frfo_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module frfo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/frfo_front.sv -----
// Front end: accepts items, classifies them and queues them for the engine.
// Depends on frfo_pkg and frfo_ifs.
module frfo_front import frfo_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic     clk,
  input  logic     rst,
  frfo_in_if.sink  in_ch,
  input  logic     hold,
  output item_t    q_item,
  output logic     q_valid,
  input  logic     q_pop
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  item_t          fifo [DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [PW:0]    cnt;
  item_t          cls;
  logic           push;
  logic           pop;

  always_comb begin
    cls.pos_x  = in_ch.pos_x;
    cls.pos_y  = in_ch.pos_y;
    cls.color  = in_ch.pixel_color;
    cls.stored = (32'(in_ch.pos_x) < MAX_WIDTH) && (32'(in_ch.pos_y) < MAX_HEIGHT);
    if (in_ch.cmd == CMD_QUERY) begin
      cls.op = OP_QUERY;
    end else if (in_ch.last_pixel) begin
      cls.op = OP_FIND;
    end else begin
      cls.op = OP_WRITE;
    end
  end

  assign in_ch.ready = !hold && (cnt != (PW+1)'(DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = cnt != '0;
  assign pop = q_pop && q_valid;
  assign q_item = fifo[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        fifo[wp] <= cls;
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- design/frfo_back.sv -----
// Back end: pixel store, region flood fill, rectangle scan and point queries.
// Depends on frfo_pkg, frfo_ifs and frfo_ram.
module frfo_back import frfo_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  item_t      q_item,
  input  logic       q_valid,
  output logic       q_pop,
  output logic       clearing,
  frfo_out_if.source out_ch
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(CELLS);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int QW = XW + YW;
  localparam int TW = AW + 1;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_SEEDW = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_POPW  = 4'd5;
  localparam logic [3:0] S_NB    = 4'd6;
  localparam logic [3:0] S_NBW   = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_SCANW = 4'd9;
  localparam logic [3:0] S_RECT  = 4'd10;
  localparam logic [3:0] S_QNB   = 4'd11;
  localparam logic [3:0] S_QNBW  = 4'd12;
  localparam logic [3:0] S_RES   = 4'd13;

  typedef struct packed {
    logic          ok;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } pos_t;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
  endfunction

  function automatic pos_t nb_of(input logic [1:0] dir, input logic [XW-1:0] x,
                                 input logic [YW-1:0] y, input logic [CW-1:0] w,
                                 input logic [HW-1:0] h);
    pos_t p;
    p.ok = 1'b0;
    p.x  = x;
    p.y  = y;
    case (dir)
      DIR_LEFT: begin
        p.ok = x != '0;
        p.x  = x - XW'(1);
      end
      DIR_RIGHT: begin
        p.ok = (CW'(x) + CW'(1)) < w;
        p.x  = x + XW'(1);
      end
      DIR_UP: begin
        p.ok = y != '0;
        p.y  = y - YW'(1);
      end
      DIR_DOWN: begin
        p.ok = (HW'(y) + HW'(1)) < h;
        p.y  = y + YW'(1);
      end
      default: begin
        p.ok = 1'b0;
      end
    endcase
    return p;
  endfunction

  function automatic logic interior(input pos_t p, input logic [CW-1:0] w,
                                    input logic [HW-1:0] h);
    return (p.x != '0) && (CW'(p.x) != w - CW'(1)) &&
           (p.y != '0) && (HW'(p.y) != h - HW'(1));
  endfunction

  logic [3:0]    state;
  logic          finding;
  logic [AW-1:0] caddr;
  logic [TW-1:0] head;
  logic [TW-1:0] tail;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [2:0]    k;
  logic [23:0]   active;
  logic [4:0]    qm;
  logic [4:0]    qi;
  logic          rkind;
  logic          rok;
  logic [7:0]    rl;
  logic [7:0]    rt;
  logic [8:0]    rw;
  logic [8:0]    rh;
  logic          have_prev;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [YW-1:0] tfull;
  logic [YW-1:0] lastrow;
  logic          ov;
  res_t          res;

  logic [CW-1:0] ew;
  logic [HW-1:0] eh;
  pos_t          bp;
  pos_t          qp;

  logic          pwe;
  logic [AW-1:0] pwaddr;
  logic [AW-1:0] praddr;
  logic [23:0]   prdata;
  logic          mwe;
  logic [AW-1:0] mwaddr;
  logic [1:0]    mwdata;
  logic [AW-1:0] mraddr;
  logic [1:0]    mrdata;
  logic          qwe;
  logic [QW-1:0] qwdata;
  logic [QW-1:0] qrdata;
  logic          slot_free;

  always_comb begin
    if (cfg.width == '0) begin
      ew = CW'(1);
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      ew = CW'(MAX_WIDTH);
    end else begin
      ew = CW'(cfg.width);
    end
    if (cfg.height == '0) begin
      eh = HW'(1);
    end else if (32'(cfg.height) > MAX_HEIGHT) begin
      eh = HW'(MAX_HEIGHT);
    end else begin
      eh = HW'(cfg.height);
    end
  end

  always_comb begin
    bp = nb_of(k[1:0], cx, cy, ew, eh);
    if (k == 3'd0) begin
      qp.ok = 1'b1;
      qp.x  = cx;
      qp.y  = cy;
    end else begin
      qp = nb_of(2'(k - 3'd1), cx, cy, ew, eh);
    end
  end

  assign slot_free = !ov || out_ch.ready;
  assign clearing  = (state == S_CLR) && !finding;

  always_comb begin
    q_pop  = 1'b0;
    pwe    = 1'b0;
    pwaddr = addr_of(XW'(q_item.pos_x), YW'(q_item.pos_y));
    praddr = addr_of(bp.x, bp.y);
    mwe    = 1'b0;
    mwaddr = addr_of(bp.x, bp.y);
    mwdata = 2'b10;
    mraddr = addr_of(bp.x, bp.y);
    qwe    = 1'b0;
    qwdata = {bp.y, bp.x};
    case (state)
      S_IDLE: begin
        q_pop = q_valid;
        pwe   = q_valid && (q_item.op != OP_QUERY) && q_item.stored;
      end
      S_CLR: begin
        mwe    = 1'b1;
        mwaddr = caddr;
        mwdata = 2'b00;
      end
      S_SEED: begin
        praddr = '0;
      end
      S_SEEDW: begin
        mwe    = cfg.seed;
        mwaddr = '0;
        qwe    = cfg.seed;
        qwdata = '0;
      end
      S_POPW: begin
        mwe    = 1'b1;
        mwaddr = addr_of(qrdata[XW-1:0], qrdata[QW-1:XW]);
        mwdata = 2'b11;
      end
      S_NBW: begin
        mwe = !mrdata[1] && (prdata == active);
        qwe = mwe;
      end
      S_SCAN: begin
        mraddr = addr_of(cx, cy);
      end
      S_QNB: begin
        mraddr = addr_of(qp.x, qp.y);
      end
      default: begin
      end
    endcase
  end

  frfo_ram #(.WIDTH(24), .DEPTH(CELLS)) u_pix (
    .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(q_item.color),
    .raddr(praddr), .rdata(prdata)
  );

  frfo_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
    .raddr(mraddr), .rdata(mrdata)
  );

  frfo_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
    .clk(clk), .we(qwe), .waddr(tail[AW-1:0]), .wdata(qwdata),
    .raddr(head[AW-1:0]), .rdata(qrdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      finding <= 1'b0;
      caddr   <= '0;
      head    <= '0;
      tail    <= '0;
      ov      <= 1'b0;
      rok     <= 1'b0;
      rl      <= '0;
      rt      <= '0;
      rw      <= '0;
      rh      <= '0;
      active  <= '0;
    end else begin
      if (out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_FIND) begin
              finding   <= 1'b1;
              caddr     <= '0;
              head      <= '0;
              tail      <= '0;
              qm        <= '0;
              qi        <= '0;
              rok       <= 1'b0;
              rl        <= '0;
              rt        <= '0;
              rw        <= '0;
              rh        <= '0;
              have_prev <= 1'b0;
              rkind     <= KIND_FIND;
              state     <= S_CLR;
            end else if (q_item.op == OP_QUERY) begin
              cx    <= XW'(q_item.pos_x);
              cy    <= YW'(q_item.pos_y);
              k     <= '0;
              qm    <= '0;
              qi    <= '0;
              rkind <= KIND_QUERY;
              if ((32'(q_item.pos_x) < 32'(ew)) && (32'(q_item.pos_y) < 32'(eh))) begin
                state <= S_QNB;
              end else begin
                state <= S_RES;
              end
            end
          end
        end
        S_CLR: begin
          caddr <= caddr + AW'(1);
          if (caddr == AW'(CELLS - 1)) begin
            state <= finding ? S_SEED : S_IDLE;
          end
        end
        S_SEED: begin
          state <= S_SEEDW;
        end
        S_SEEDW: begin
          cx <= '0;
          cy <= '0;
          if (cfg.seed) begin
            active <= prdata;
            tail   <= TW'(1);
            state  <= S_POP;
          end else begin
            active <= cfg.color;
            state  <= S_SCAN;
          end
        end
        S_POP: begin
          if (head == tail) begin
            cx    <= '0;
            cy    <= '0;
            state <= S_SCAN;
          end else begin
            head  <= head + TW'(1);
            state <= S_POPW;
          end
        end
        S_POPW: begin
          cx    <= qrdata[XW-1:0];
          cy    <= qrdata[QW-1:XW];
          k     <= '0;
          state <= S_NB;
        end
        S_NB: begin
          if (bp.ok) begin
            state <= S_NBW;
          end else if (k == 3'd3) begin
            state <= S_POP;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_NBW: begin
          if (!mrdata[1] && (prdata == active)) begin
            tail <= tail + TW'(1);
          end
          if (k == 3'd3) begin
            state <= S_POP;
          end else begin
            k     <= k + 3'd1;
            state <= S_NB;
          end
        end
        S_SCAN: begin
          state <= S_SCANW;
        end
        S_SCANW: begin
          if (mrdata[0]) begin
            if (have_prev && (py == cy) && ((CW'(px) + CW'(1)) != CW'(cx))) begin
              if (!rok) begin
                rok   <= 1'b1;
                rl    <= 8'(32'(px) + 1);
                rw    <= 9'(32'(cx) - 32'(px) - 1);
                rt    <= 8'(cy);
                tfull <= cy;
              end
              lastrow <= cy;
            end
            have_prev <= 1'b1;
            px <= cx;
            py <= cy;
          end
          if ((CW'(cx) + CW'(1)) == ew) begin
            cx <= '0;
            if ((HW'(cy) + HW'(1)) == eh) begin
              state <= S_RECT;
            end else begin
              cy    <= cy + YW'(1);
              state <= S_SCAN;
            end
          end else begin
            cx    <= cx + XW'(1);
            state <= S_SCAN;
          end
        end
        S_RECT: begin
          if (rok) begin
            rh <= 9'(32'(lastrow) - 32'(tfull) + 1);
          end
          finding <= 1'b0;
          state   <= S_RES;
        end
        S_QNB: begin
          if (qp.ok) begin
            state <= S_QNBW;
          end else if (k == 3'd4) begin
            state <= S_RES;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_QNBW: begin
          qm[k] <= mrdata[0];
          qi[k] <= mrdata[0] && interior(qp, ew, eh);
          if (k == 3'd4) begin
            state <= S_RES;
          end else begin
            k     <= k + 3'd1;
            state <= S_QNB;
          end
        end
        S_RES: begin
          if (slot_free) begin
            ov    <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RES) && slot_free) begin
      res.kind        <= rkind;
      res.in_frame    <= qm[0];
      res.frame_edge  <= qi[0] && (!qm[1] || !qm[2] || !qm[3] || !qm[4]);
      res.off_edge    <= !qm[0] && (qi[4:1] != '0);
      res.rect_found  <= rok;
      res.rect_left   <= rl;
      res.rect_top    <= rt;
      res.rect_width  <= rw;
      res.rect_height <= rh;
    end
  end

  assign out_ch.valid       = ov;
  assign out_ch.result_kind = res.kind;
  assign out_ch.in_frame    = res.in_frame;
  assign out_ch.frame_edge  = res.frame_edge;
  assign out_ch.off_edge    = res.off_edge;
  assign out_ch.rect_found  = res.rect_found;
  assign out_ch.rect_left   = res.rect_left;
  assign out_ch.rect_top    = res.rect_top;
  assign out_ch.rect_width  = res.rect_width;
  assign out_ch.rect_height = res.rect_height;

  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("frontier head passed tail");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) tail <= TW'(CELLS))
    else $error("frontier overflow");
  a_edge_member: assert property (@(posedge clk) disable iff (rst)
    ov && res.frame_edge |-> res.in_frame)
    else $error("frame edge outside region");
  a_off_nonmember: assert property (@(posedge clk) disable iff (rst)
    ov && res.off_edge |-> !res.in_frame)
    else $error("off edge inside region");

endmodule
